>>> rtl/core/awbr_pkg.sv
// Shared types and constants for the alpha-weighted box resizer.
// No dependencies; imported by awbr_div, the core and the testbench.
package awbr_pkg;

    localparam int DEF_MAX_SOURCE_WIDTH  = 256;
    localparam int DEF_MAX_SOURCE_HEIGHT = 256;
    localparam int DEF_MAX_DEST_SIZE     = 256;

    localparam int CFG_W    = 9;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int IN_DW    = 48;
    localparam int OUT_DW   = 32;

    localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 9'd64;
    localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 9'd64;
    localparam logic [CFG_W-1:0] RST_DEST_WIDTH    = 9'd16;
    localparam logic [CFG_W-1:0] RST_DEST_HEIGHT   = 9'd16;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_DEST_WIDTH    = 2'd2,
        REG_DEST_HEIGHT   = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SDIV,
        ST_SWAIT,
        ST_BOX,
        ST_ROW,
        ST_WALK,
        ST_DRAIN,
        ST_FDIV,
        ST_FWAIT,
        ST_OUT
    } state_t;

endpackage

>>> rtl/core/awbr_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module awbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/core/awbr_div.sv
// Restoring divider, one quotient bit per cycle, for bounded quotients.
// Caller guarantees dividend >> steps < divisor. Depends on awbr_pkg.
module awbr_div #(
    parameter int DVW = 32,
    parameter int DSW = 16,
    parameter int QW  = 8,
    parameter int STW = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [DVW-1:0]  dividend,
    input  logic [DSW-1:0]  divisor,
    input  logic [STW-1:0]  steps,
    output logic            done,
    output logic [QW-1:0]   quotient
);
    import awbr_pkg::*;

    logic [DSW-1:0] rem_reg;
    logic [DVW-1:0] dvd_reg;
    logic [DSW-1:0] dsr_reg;
    logic [QW-1:0]  q_reg;
    logic [STW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DSW:0]   trial;
    logic           ge;

    assign trial = {rem_reg, dvd_reg[DVW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
                rem_reg  <= DSW'(dividend >> steps);
                dvd_reg  <= dividend << (DVW - 32'(steps));
                dsr_reg  <= divisor;
                q_reg    <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? DSW'(trial - {1'b0, dsr_reg}) : DSW'(trial);
                dvd_reg <= dvd_reg << 1;
                q_reg   <= {q_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

>>> rtl/core/alpha_weighted_box_resize_core.sv
// Area-averaging RGBA resizer. A load transfer (tuser 0) writes one source pixel into the
// pixel store in raster order. A compute transfer (tuser 1) returns one pixel: alpha-weighted
// mean colour and plain mean alpha over its source box. A compute item first finds the box
// edges, sets up the walk, reads the box one source pixel per cycle, drains the read and
// multiply stages and runs the final divisions, all divisions on one shared restoring
// divider, and then hands the result to the output register.
// The store has no reset: only boxes over loaded pixels give defined results.
module alpha_weighted_box_resize_core #(
    parameter int MAX_SOURCE_WIDTH  = awbr_pkg::DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_SOURCE_HEIGHT = awbr_pkg::DEF_MAX_SOURCE_HEIGHT,
    parameter int MAX_DEST_SIZE     = awbr_pkg::DEF_MAX_DEST_SIZE
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // red, green, blue, alpha, dest_x, dest_y (8 bits each, low first)
    input  logic [awbr_pkg::IN_DW-1:0]  s_tdata,
    // kind
    input  logic [0:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_red, out_green, out_blue, out_alpha (low first)
    output logic [awbr_pkg::OUT_DW-1:0] m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [awbr_pkg::APB_AW-1:0] paddr,
    input  logic [awbr_pkg::APB_DW-1:0] pwdata,
    output logic [awbr_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import awbr_pkg::*;

    localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int MSS   = MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT ?
                           MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
    localparam int SWW   = $clog2(MSS + 1);
    localparam int DDW   = $clog2(MAX_DEST_SIZE + 1);
    localparam int QW    = SWW > 8 ? SWW : 8;
    localparam int STW   = $clog2(QW + 1);
    localparam int PW    = 9 + SWW;
    localparam int RW    = 16 + NW;
    localparam int SAW   = 8 + NW;
    localparam int DVW   = RW;
    localparam int DSW   = SAW > DDW ? SAW : DDW;

    // configuration
    logic [CFG_W-1:0] sw_cfg_reg, sh_cfg_reg, dw_cfg_reg, dh_cfg_reg;
    logic             cfg_wr;
    logic [SWW-1:0]   sw_eff, sh_eff;
    logic [DDW-1:0]   dw_eff, dh_eff;
    logic [NW-1:0]    area;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_cfg_reg <= RST_SOURCE_WIDTH;
            sh_cfg_reg <= RST_SOURCE_HEIGHT;
            dw_cfg_reg <= RST_DEST_WIDTH;
            dh_cfg_reg <= RST_DEST_HEIGHT;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_SOURCE_WIDTH:  sw_cfg_reg <= pwdata[CFG_W-1:0];
                REG_SOURCE_HEIGHT: sh_cfg_reg <= pwdata[CFG_W-1:0];
                REG_DEST_WIDTH:    dw_cfg_reg <= pwdata[CFG_W-1:0];
                REG_DEST_HEIGHT:   dh_cfg_reg <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_SOURCE_WIDTH:  prdata = APB_DW'(sw_cfg_reg);
            REG_SOURCE_HEIGHT: prdata = APB_DW'(sh_cfg_reg);
            REG_DEST_WIDTH:    prdata = APB_DW'(dw_cfg_reg);
            REG_DEST_HEIGHT:   prdata = APB_DW'(dh_cfg_reg);
        endcase
    end

    assign sw_eff = (sw_cfg_reg == '0) ? SWW'(1) :
                    (32'(sw_cfg_reg) > MAX_SOURCE_WIDTH) ? SWW'(MAX_SOURCE_WIDTH) :
                    SWW'(sw_cfg_reg);
    assign sh_eff = (sh_cfg_reg == '0) ? SWW'(1) :
                    (32'(sh_cfg_reg) > MAX_SOURCE_HEIGHT) ? SWW'(MAX_SOURCE_HEIGHT) :
                    SWW'(sh_cfg_reg);
    assign dw_eff = (dw_cfg_reg == '0) ? DDW'(1) :
                    (32'(dw_cfg_reg) > MAX_DEST_SIZE) ? DDW'(MAX_DEST_SIZE) :
                    DDW'(dw_cfg_reg);
    assign dh_eff = (dh_cfg_reg == '0) ? DDW'(1) :
                    (32'(dh_cfg_reg) > MAX_DEST_SIZE) ? DDW'(MAX_DEST_SIZE) :
                    DDW'(dh_cfg_reg);
    assign area   = NW'(sw_eff) * NW'(sh_eff);

    // control
    state_t         state_reg, state_next;
    logic           s_accept, load_we;
    logic [AW-1:0]  ptr_reg, ptr_eff;
    logic [NW-1:0]  ptr_inc;
    logic [7:0]     x_in, y_in, x_reg, y_reg;
    logic [1:0]     sel_reg;
    logic [PW-1:0]  prod_reg;
    logic [QW-1:0]  span_reg [4];
    logic [SWW-1:0] x0_reg, x1_reg, y0_reg, y1_reg, sx_reg, sy_reg;
    logic [AW-1:0]  base_reg, rd_addr;
    logic           walk_last, row_last;
    logic           rd_vld_reg, mul_vld_reg;
    logic [15:0]    mr_reg, mg_reg, mb_reg;
    logic [7:0]     ma_reg;
    logic [RW-1:0]  acc_r_reg, acc_g_reg, acc_b_reg;
    logic [SAW-1:0] acc_a_reg;
    logic [NW-1:0]  cnt_reg;
    logic [7:0]     res_reg [4];
    logic           m_tvalid_reg;
    logic [OUT_DW-1:0] m_tdata_reg;
    logic [31:0]    ram_rdata;
    logic           div_start, div_done;
    logic [DVW-1:0] div_dividend;
    logic [DSW-1:0] div_divisor;
    logic [STW-1:0] div_steps;
    logic [QW-1:0]  div_q;
    logic [8:0]     mul_d;
    logic [SWW-1:0] mul_s;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign load_we  = s_accept & (s_tuser[0] == KIND_LOAD);

    assign ptr_eff  = (NW'(ptr_reg) >= area) ? '0 : ptr_reg;
    assign ptr_inc  = NW'(ptr_eff) + NW'(1);

    assign x_in = (32'(s_tdata[39:32]) >= 32'(dw_eff)) ? 8'(dw_eff - 1'b1) : s_tdata[39:32];
    assign y_in = (32'(s_tdata[47:40]) >= 32'(dh_eff)) ? 8'(dh_eff - 1'b1) : s_tdata[47:40];

    assign row_last  = (sx_reg == x1_reg - 1'b1);
    assign walk_last = row_last && (sy_reg == y1_reg - 1'b1);
    assign rd_addr   = base_reg + AW'(sx_reg);

    function automatic logic [SWW-1:0] fix_hi(input logic [QW-1:0] lo,
                                              input logic [QW-1:0] hi,
                                              input logic [SWW-1:0] sn);
        logic [QW-1:0] h;
        h = (hi <= lo) ? lo + 1'b1 : hi;
        if (h > QW'(sn)) begin
            h = QW'(sn);
        end
        return SWW'(h);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = DVW'(prod_reg);
        div_divisor  = sel_reg[1] ? DSW'(dh_eff) : DSW'(dw_eff);
        div_steps    = STW'(SWW);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser[0] == KIND_COMPUTE) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_SDIV;
            ST_SDIV: begin
                div_start  = 1'b1;
                state_next = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (div_done) begin
                    state_next = (sel_reg == 2'd3) ? ST_BOX : ST_MUL;
                end
            end
            ST_BOX:   state_next = ST_ROW;
            ST_ROW:   state_next = ST_WALK;
            ST_WALK: begin
                if (walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mul_vld_reg) begin
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV: begin
                div_start  = 1'b1;
                div_steps  = STW'(8);
                state_next = ST_FWAIT;
                unique case (sel_reg)
                    2'd0: div_dividend = acc_r_reg;
                    2'd1: div_dividend = acc_g_reg;
                    2'd2: div_dividend = acc_b_reg;
                    2'd3: div_dividend = DVW'(acc_a_reg);
                endcase
                div_divisor = (sel_reg == 2'd3) ? DSW'(cnt_reg) : DSW'(acc_a_reg);
            end
            ST_FWAIT: begin
                if (div_done) begin
                    state_next = (sel_reg == 2'd3) ? ST_OUT : ST_FDIV;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign mul_d = sel_reg[0] ? {1'b0, sel_reg[1] ? y_reg : x_reg} + 9'd1
                              : {1'b0, sel_reg[1] ? y_reg : x_reg};
    assign mul_s = sel_reg[1] ? sh_eff : sw_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            sel_reg     <= '0;
        end else begin
            if (load_we) begin
                ptr_reg <= (ptr_inc >= area) ? '0 : AW'(ptr_inc);
            end
            rd_vld_reg  <= (state_reg == ST_WALK);
            mul_vld_reg <= rd_vld_reg;
            if (state_reg == ST_IDLE) begin
                sel_reg <= '0;
            end else if (div_done) begin
                sel_reg <= sel_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg <= x_in;
            y_reg <= y_in;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= PW'(mul_d) * PW'(mul_s);
        end
        if (state_reg == ST_SWAIT && div_done) begin
            span_reg[sel_reg] <= div_q;
        end
        if (state_reg == ST_FWAIT && div_done) begin
            res_reg[sel_reg] <= (sel_reg != 2'd3 && acc_a_reg == '0) ? 8'd0 : div_q[7:0];
        end
        if (state_reg == ST_BOX) begin
            x0_reg    <= SWW'(span_reg[0]);
            x1_reg    <= fix_hi(span_reg[0], span_reg[1], sw_eff);
            y0_reg    <= SWW'(span_reg[2]);
            y1_reg    <= fix_hi(span_reg[2], span_reg[3], sh_eff);
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
            acc_a_reg <= '0;
            cnt_reg   <= '0;
        end else if (mul_vld_reg) begin
            acc_r_reg <= acc_r_reg + RW'(mr_reg);
            acc_g_reg <= acc_g_reg + RW'(mg_reg);
            acc_b_reg <= acc_b_reg + RW'(mb_reg);
            acc_a_reg <= acc_a_reg + SAW'(ma_reg);
            cnt_reg   <= cnt_reg + 1'b1;
        end
        if (state_reg == ST_ROW) begin
            base_reg <= AW'(NW'(y0_reg) * NW'(sw_eff));
            sx_reg   <= x0_reg;
            sy_reg   <= y0_reg;
        end else if (state_reg == ST_WALK) begin
            if (row_last) begin
                sx_reg   <= x0_reg;
                sy_reg   <= sy_reg + 1'b1;
                base_reg <= base_reg + AW'(sw_eff);
            end else begin
                sx_reg <= sx_reg + 1'b1;
            end
        end
        // colour times alpha, registered ahead of the accumulators
        mr_reg <= ram_rdata[7:0]   * ram_rdata[31:24];
        mg_reg <= ram_rdata[15:8]  * ram_rdata[31:24];
        mb_reg <= ram_rdata[23:16] * ram_rdata[31:24];
        ma_reg <= ram_rdata[31:24];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && !m_tvalid_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && !m_tvalid_reg) begin
            m_tdata_reg <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    awbr_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (load_we),
        .addr  (load_we ? ptr_eff : rd_addr),
        .wdata (s_tdata[31:0]),
        .rdata (ram_rdata)
    );

    awbr_div #(
        .DVW(DVW),
        .DSW(DSW),
        .QW (QW),
        .STW(STW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    a_store_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load_we |-> state_reg == ST_IDLE)
        else $error("store written outside idle");

    a_walk_in_box: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> (sx_reg < x1_reg) && (x0_reg < x1_reg) && (sy_reg < y1_reg))
        else $error("walk left the source box");

    a_read_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> $past(state_reg == ST_WALK))
        else $error("read data without a walk read");

    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && !rd_vld_reg && !mul_vld_reg) |=> state_reg == ST_FDIV)
        else $error("drain did not hand over to division");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !m_tvalid_reg) |=> m_tvalid_reg)
        else $error("result not presented");
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for alpha_weighted_box_resize_core: loads source images, requests
// destination pixels and checks each one against a predictor of the box average.
// Depends on awbr_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import awbr_pkg::*;

    typedef struct {
        logic       kind;
        logic [7:0] red, green, blue, alpha, dx, dy;
    } pix_item_t;

    typedef struct {
        logic [7:0] red, green, blue, alpha;
    } rgba_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata = '0;
    logic [0:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_DW-1:0]   m_tdata;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    alpha_weighted_box_resize_core DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    pix_item_t   pending_items[$];
    rgba_t       expected_pixels[$];
    logic [31:0] pix_store [0:65535];
    int unsigned load_ptr;
    logic [CFG_W-1:0] cfg_sw = RST_SOURCE_WIDTH, cfg_sh = RST_SOURCE_HEIGHT;
    logic [CFG_W-1:0] cfg_dw = RST_DEST_WIDTH, cfg_dh = RST_DEST_HEIGHT;
    int  send_idle = 0, recv_stall = 0;
    int  mismatches = 0;
    bit  hold_phase = 0, hold_done = 0;
    int  hold_left = 0;

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    // compute one destination pixel from the shadow store, or store a loaded pixel and advance the load pointer
    task automatic apply_item(pix_item_t it);
        int unsigned sw, sh, dw, dh, area, x, y, x0, x1, y0, y1;
        longint unsigned r, g, b, a, n;
        logic [31:0] px;
        rgba_t res;
        sw = clamp_dim(cfg_sw); sh = clamp_dim(cfg_sh);
        dw = clamp_dim(cfg_dw); dh = clamp_dim(cfg_dh);
        area = sw * sh;
        if (it.kind == KIND_LOAD) begin
            if (load_ptr >= area) load_ptr = 0;
            pix_store[load_ptr[15:0]] = {it.alpha, it.blue, it.green, it.red};
            load_ptr++;
            if (load_ptr >= area) load_ptr = 0;
            return;
        end
        x = (it.dx >= dw) ? dw - 1 : it.dx;
        y = (it.dy >= dh) ? dh - 1 : it.dy;
        x0 = x * sw / dw; x1 = (x + 1) * sw / dw;
        if (x1 <= x0) x1 = x0 + 1;
        if (x1 > sw) x1 = sw;
        y0 = y * sh / dh; y1 = (y + 1) * sh / dh;
        if (y1 <= y0) y1 = y0 + 1;
        if (y1 > sh) y1 = sh;
        r = 0; g = 0; b = 0; a = 0; n = 0;
        for (int unsigned sy = y0; sy < y1; sy++)
            for (int unsigned sx = x0; sx < x1; sx++) begin
                px = pix_store[(sy * sw + sx) % 65536];
                r += px[7:0] * px[31:24];
                g += px[15:8] * px[31:24];
                b += px[23:16] * px[31:24];
                a += px[31:24];
                n++;
            end
        res.red   = a ? 8'(r / a) : 8'd0;
        res.green = a ? 8'(g / a) : 8'd0;
        res.blue  = a ? 8'(b / a) : 8'd0;
        res.alpha = n ? 8'(a / n) : 8'd0;
        expected_pixels.push_back(res);
    endtask

    // sender
    always @(posedge aclk) begin
        pix_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.kind;
                s_tdata  <= {it.dy, it.dx, it.alpha, it.blue, it.green, it.red};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // input monitor feeds the predictor
    always @(posedge aclk) begin
        pix_item_t it;
        if (aresetn && s_tvalid && s_tready) begin
            it.kind = s_tuser[0];
            {it.dy, it.dx, it.alpha, it.blue, it.green, it.red} = s_tdata;
            apply_item(it);
        end
    end

    // receiver, with one long hold-off in the pressure phase
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_phase && !hold_done && m_tvalid) begin
            m_tready  <= 1'b0;
            hold_left <= 1500;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        rgba_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            {got.alpha, got.blue, got.green, got.red} = m_tdata;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer %h", m_tdata);
            end else begin
                want = expected_pixels.pop_front();
                if ({want.alpha, want.blue, want.green, want.red} != m_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: exp r%0d g%0d b%0d a%0d got r%0d g%0d b%0d a%0d",
                                 want.red, want.green, want.blue, want.alpha,
                                 got.red, got.green, got.blue, got.alpha);
                end
            end
        end
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_pixels.size() != 0);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'(4 * int'(idx)); pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  cfg_sw = val[CFG_W-1:0];
            REG_SOURCE_HEIGHT: cfg_sh = val[CFG_W-1:0];
            REG_DEST_WIDTH:    cfg_dw = val[CFG_W-1:0];
            default:           cfg_dh = val[CFG_W-1:0];
        endcase
    endtask

    function automatic pix_item_t load_item();
        pix_item_t it;
        it.kind  = KIND_LOAD;
        it.red   = 8'($urandom); it.green = 8'($urandom); it.blue = 8'($urandom);
        it.alpha = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
        if ($urandom_range(7) == 0) it.alpha = 8'hff;
        it.dx = 8'($urandom); it.dy = 8'($urandom);
        return it;
    endfunction

    function automatic pix_item_t compute_item();
        pix_item_t it;
        it = load_item();
        it.kind = KIND_COMPUTE;
        if ($urandom_range(3) == 0) begin
            it.dx = 8'($urandom); it.dy = 8'($urandom);
        end else begin
            it.dx = 8'($urandom_range(clamp_dim(cfg_dw) - 1));
            it.dy = 8'($urandom_range(clamp_dim(cfg_dh) - 1));
        end
        return it;
    endfunction

    task automatic set_sizes(int sw, int sh, int dw, int dh);
        wait_drained();
        repeat (20) @(posedge aclk);
        reg_write(REG_SOURCE_WIDTH, sw);
        reg_write(REG_SOURCE_HEIGHT, sh);
        reg_write(REG_DEST_WIDTH, dw);
        reg_write(REG_DEST_HEIGHT, dh);
    endtask

    initial begin
        pix_item_t it;
        int sizes[10][4];
        int area;
        sizes = '{'{0, 0, 0, 0}, '{511, 1, 1, 1}, '{1, 511, 3, 0},
                  '{8, 8, 16, 16}, '{16, 16, 5, 7}, '{256, 1, 256, 511},
                  '{3, 5, 2, 3}, '{12, 10, 7, 4}, '{9, 14, 9, 2}, '{16, 16, 16, 16}};
        load_ptr = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: 4x4 source to 2x2, top-left box fully transparent, extremes of fields
        set_sizes(4, 4, 2, 2);
        for (int i = 0; i < 16; i++) begin
            it = load_item();
            if (i % 4 < 2 && i / 4 < 2) it.alpha = 8'd0;
            if (i == 2) {it.red, it.green, it.blue, it.alpha, it.dx, it.dy} = '1;
            if (i == 3) {it.red, it.green, it.blue, it.dx, it.dy} = '0;
            pending_items.push_back(it);
        end
        for (int i = 0; i < 6; i++) begin
            it = load_item();
            it.kind = KIND_COMPUTE;
            it.dx = (i < 4) ? 8'(i % 2) : 8'hff;
            it.dy = (i < 4) ? 8'(i / 2) : 8'(i - 4);
            pending_items.push_back(it);
        end

        for (int p = 0; p < 10; p++) begin
            set_sizes(sizes[p][0], sizes[p][1], sizes[p][2], sizes[p][3]);
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 80; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 80; end
                default: begin send_idle = 33; recv_stall = 33; end
            endcase
            hold_phase = (p == 4);
            // fill the whole source area from wherever the pointer stands
            area = clamp_dim(cfg_sw) * clamp_dim(cfg_sh);
            for (int i = 0; i < area; i++) pending_items.push_back(load_item());
            for (int i = 0; i < 20; i++) begin
                if (p == 6 && i == 10) wait_drained();
                pending_items.push_back(($urandom_range(9) < 6) ? compute_item() : load_item());
            end
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end
endmodule
